[rtl/swdc_pkg.sv]
// Shared constants and types for the sliding-window distinct-count unit.
`timescale 1ns / 1ps

package swdc_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int WINDOW_MAX  = 1024;
    localparam int VALUE_COUNT = 1 << VALUE_BITS;
    localparam int RING_AW     = $clog2(WINDOW_MAX);
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
    localparam int WIN_W       = 11;
    localparam int SAMPLE_W    = 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 2;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);
    localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

    localparam logic [PADDR_W-3:0] REG_WINDOW_SIZE = '0;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [CNT_W-1:0]      t_count;

    typedef struct packed {
        t_value enter_val;
        t_value leave_val;
        logic   leave_en;
        logic   emit;
    } t_work;

    typedef enum logic [1:0] {
        M_CLEAR = 2'b01,
        M_RUN   = 2'b10
    } t_mem_mode;

endpackage

[rtl/swdc_front.sv]
// Front end: accepts samples, tracks window fill and ring position, fetches leaving value.
`timescale 1ns / 1ps

module swdc_front import swdc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_restart,
    input  logic                i_hold,
    input  t_count              i_win,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample_value,
    input  logic                i_full,
    output logic                o_push,
    output t_work               o_work
);

    logic [RING_AW-1:0] r_pos;
    logic [RING_AW-1:0] n_pos;
    t_count             r_fill;
    t_count             n_fill;
    logic               r_s1_valid;
    t_value             r_s1_enter;
    logic               r_s1_leave_en;
    logic               r_s1_emit;
    t_value             r_ring_q;
    t_value             r_ring [WINDOW_MAX];

    logic   accept;
    logic   leave_now;
    t_count fill_inc;
    t_count pos_inc;
    t_value enter_val;

    assign o_ready   = !i_hold && (!r_s1_valid || !i_full);
    assign accept    = i_valid && o_ready;
    assign o_push    = r_s1_valid && !i_full;
    assign enter_val = t_value'(i_sample_value);

    assign leave_now = (r_fill >= i_win);
    assign fill_inc  = r_fill + t_count'(1);
    assign pos_inc   = t_count'(r_pos) + t_count'(1);

    always_comb begin
        n_fill = leave_now ? r_fill : fill_inc;
        n_pos  = (pos_inc >= i_win) ? '0 : RING_AW'(pos_inc);
    end

    assign o_work = '{enter_val: r_s1_enter, leave_val: r_ring_q,
                      leave_en: r_s1_leave_en, emit: r_s1_emit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_pos      <= '0;
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos      <= n_pos;
                r_fill     <= n_fill;
                r_s1_valid <= 1'b1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_enter    <= enter_val;
            r_s1_leave_en <= leave_now;
            r_s1_emit     <= leave_now || (fill_inc >= i_win);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_pos] <= enter_val;
            r_ring_q      <= r_ring[r_pos];
        end
    end

endmodule

[rtl/swdc_queue.sv]
// Short queue of classified words between front end and count engine.
`timescale 1ns / 1ps

module swdc_queue import swdc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_flush,
    input  logic  i_push,
    input  t_work i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_work o_data,
    output logic  o_empty
);

    t_work                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr;
    logic [QUEUE_AW-1:0]  r_rd;
    logic [QUEUE_AW:0]    r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            r_cnt <= r_cnt + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

[rtl/swdc_back.sv]
// Count engine: count memory read-modify-writes, distinct total, clearing pass, result buffer.
`timescale 1ns / 1ps

module swdc_back import swdc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_restart,
    input  t_work  i_work,
    input  logic   i_empty,
    output logic   o_pop,
    output logic   o_clearing,
    output logic   o_valid,
    input  logic   i_ready,
    output t_count o_distinct_count
);

    t_mem_mode          r_mode;
    t_value             r_clr_addr;
    t_count             r_cnt_mem [VALUE_COUNT];
    t_count             r_rdata;
    logic               r_byp;
    t_count             r_byp_data;
    logic               r_e_valid;
    t_work              r_e_work;
    logic               r_f_valid;
    t_value             r_f_enter;
    logic               r_f_emit;
    t_count             r_total;
    t_count             n_total;
    t_count             r_ofifo [OUT_DEPTH];
    logic [OUT_AW-1:0]  r_owr;
    logic [OUT_AW-1:0]  r_ord;
    logic [OUT_CW-1:0]  r_ocnt;
    logic [OUT_CW-1:0]  r_credit;

    logic   start;
    logic   take;
    logic   opush;
    logic   opop;
    t_value rd_addr;
    t_count fwd;
    logic   e_dec;
    t_count dec_val;
    logic   f_new;
    logic   we;
    t_value wa;
    t_count wd;

    assign o_clearing = (r_mode == M_CLEAR);
    assign take       = i_work.emit;
    assign start      = (r_mode == M_RUN) && !i_empty && !r_e_valid &&
                        (!take || (r_credit != '0));
    assign o_pop      = start;

    assign rd_addr = r_e_valid ? r_e_work.enter_val : i_work.leave_val;
    assign fwd     = r_byp ? r_byp_data : r_rdata;
    assign e_dec   = r_e_valid && r_e_work.leave_en && (fwd != '0);
    assign dec_val = fwd - t_count'(1);
    assign f_new   = r_f_valid && (fwd == '0);

    always_comb begin
        we = 1'b0;
        wa = r_clr_addr;
        wd = '0;
        priority if (r_mode == M_CLEAR) begin
            we = 1'b1;
        end else if (e_dec) begin
            we = 1'b1;
            wa = r_e_work.leave_val;
            wd = dec_val;
        end else if (r_f_valid) begin
            we = 1'b1;
            wa = r_f_enter;
            wd = fwd + t_count'(1);
        end
    end

    always_comb begin
        n_total = r_total;
        priority if (e_dec && (dec_val == '0) && (r_total != '0)) begin
            n_total = r_total - t_count'(1);
        end else if (r_f_valid) begin
            n_total = r_total + t_count'(f_new);
        end
    end

    assign opush            = r_f_valid && r_f_emit;
    assign o_valid          = (r_ocnt != '0);
    assign opop             = o_valid && i_ready;
    assign o_distinct_count = r_ofifo[r_ord];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_mode     <= M_CLEAR;
            r_clr_addr <= '0;
            r_e_valid  <= 1'b0;
            r_f_valid  <= 1'b0;
            r_total    <= '0;
            r_byp      <= 1'b0;
            r_owr      <= '0;
            r_ord      <= '0;
            r_ocnt     <= '0;
            r_credit   <= OUT_CW'(OUT_DEPTH);
        end else begin
            if (r_mode == M_CLEAR) begin
                r_clr_addr <= r_clr_addr + t_value'(1);
                if (&r_clr_addr) begin
                    r_mode <= M_RUN;
                end
            end
            r_e_valid <= start;
            r_f_valid <= r_e_valid;
            r_total   <= n_total;
            r_byp     <= we && (wa == rd_addr);
            if (opush) begin
                r_owr <= r_owr + OUT_AW'(1);
            end
            if (opop) begin
                r_ord <= r_ord + OUT_AW'(1);
            end
            r_ocnt   <= r_ocnt + OUT_CW'(opush) - OUT_CW'(opop);
            r_credit <= r_credit - OUT_CW'(start && take) + OUT_CW'(opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_e_work <= i_work;
        end
        r_f_enter  <= r_e_work.enter_val;
        r_f_emit   <= r_e_work.emit;
        r_byp_data <= wd;
        if (opush) begin
            r_ofifo[r_owr] <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_cnt_mem[wa] <= wd;
        end
        r_rdata <= r_cnt_mem[rd_addr];
    end

`ifndef NO_ASSERTIONS
    a_leave_then_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_restart)
        r_e_valid |=> r_f_valid)
        else $error("enter phase did not follow leave phase");

    a_phases_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_valid |-> !r_e_valid)
        else $error("leave and enter phases overlap");

    a_no_start_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_CLEAR) |-> !o_pop)
        else $error("word started during clearing pass");

    a_credit_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_ocnt) + 32'(r_credit) + 32'(r_e_valid && r_e_work.emit)
            + 32'(r_f_valid && r_f_emit)) == OUT_DEPTH)
        else $error("result buffer credits out of balance");
`endif

endmodule

[rtl/sliding_window_distinct_count_unit.sv]
// Samples pass the front-end register, the queue, the count engine's leave and enter
// phases and the result buffer. No sample starts in the count engine while another is in
// its leave phase, as each does two read-modify-writes on the single write port of the
// 65536-entry count memory. Reset (i_rst_n low, synchronous) and every window_size write
// start a clearing pass over the count memory; o_ready stays low until it ends.
// Top level: configuration register, front end, queue and count engine.
`timescale 1ns / 1ps

module sliding_window_distinct_count_unit import swdc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CNT_W-1:0]    o_distinct_count
);

    logic [WIN_W-1:0] r_window;
    logic             cfg_wr;
    logic             reg_hit;
    t_count           win_eff;
    logic             clearing;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    t_work            q_in;
    t_work            q_out;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_WINDOW_SIZE);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? PDATA_W'(r_window) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WIN_W'(1);
        end else if (cfg_wr) begin
            r_window <= pwdata[WIN_W-1:0];
        end
    end

    always_comb begin
        if (r_window == '0) begin
            win_eff = t_count'(1);
        end else if (32'(r_window) > 32'(WINDOW_MAX)) begin
            win_eff = t_count'(WINDOW_MAX);
        end else begin
            win_eff = t_count'(r_window);
        end
    end

    swdc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (cfg_wr),
        .i_hold         (clearing),
        .i_win          (win_eff),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_value (i_sample_value),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_work         (q_in)
    );

    swdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (cfg_wr),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    swdc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_restart        (cfg_wr),
        .i_work           (q_out),
        .i_empty          (q_empty),
        .o_pop            (q_pop),
        .o_clearing       (clearing),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_distinct_count (o_distinct_count)
    );

endmodule
